[rtl/lpcs_pkg.sv]
package lpcs_pkg;

  localparam int PIXEL_COUNT = 8;
  localparam int PIX_PTR_W   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 3;
  localparam int COLOR_W     = 32;
  localparam int TICK_W      = 12;
  localparam int LATCH_W     = 16;
  localparam int CNT_W       = 16;
  localparam int BIT_PTR_W   = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [BIT_PTR_W-1:0] BIT_FIRST = 5'd31;

  localparam logic [TICK_W-1:0]  ONE_HIGH_RST  = TICK_W'(700 / 5);
  localparam logic [TICK_W-1:0]  ONE_LOW_RST   = TICK_W'(800 / 5);
  localparam logic [TICK_W-1:0]  ZERO_HIGH_RST = TICK_W'(350 / 5);
  localparam logic [TICK_W-1:0]  ZERO_LOW_RST  = TICK_W'(600 / 5);
  localparam logic [LATCH_W-1:0] LATCH_RST     = LATCH_W'(60000 / 5);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_START = 2'd3
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ONE_HIGH  = 3'd0,
    CFG_ONE_LOW   = 3'd1,
    CFG_ZERO_HIGH = 3'd2,
    CFG_ZERO_LOW  = 3'd3,
    CFG_LATCH     = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_HIGH  = 4'b0010,
    PH_LOW   = 4'b0100,
    PH_LATCH = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0]  one_high_ticks;
    logic [TICK_W-1:0]  one_low_ticks;
    logic [TICK_W-1:0]  zero_high_ticks;
    logic [TICK_W-1:0]  zero_low_ticks;
    logic [LATCH_W-1:0] latch_ticks;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  pixel_index;
    logic [COLOR_W-1:0]  pixel_color;
  } item_t;

  typedef struct packed {
    logic data_line;
    logic busy_res;
    logic frame_done;
  } res_t;

endpackage

[rtl/lpcs_if.sv]
interface lpcs_in_if;
  logic                             valid;
  logic                             ready;
  logic [lpcs_pkg::ACTION_W-1:0]    action;
  logic [lpcs_pkg::INDEX_W-1:0]     pixel_index;
  logic [lpcs_pkg::COLOR_W-1:0]     pixel_color;

  modport source (output valid, output action, output pixel_index, output pixel_color,
                  input ready);
  modport sink (input valid, input action, input pixel_index, input pixel_color,
                output ready);
endinterface

interface lpcs_out_if;
  logic valid;
  logic ready;
  logic data_line;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output data_line, output busy_res, output frame_done,
                  input ready);
  modport sink (input valid, input data_line, input busy_res, input frame_done,
                output ready);
endinterface

[rtl/lpcs_core.sv]
module lpcs_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_en,
  input  lpcs_pkg::item_t item,
  input  lpcs_pkg::cfg_t  cfg,
  output lpcs_pkg::res_t  res
);

  logic [lpcs_pkg::COLOR_W-1:0]   store_r [lpcs_pkg::PIXEL_COUNT];
  lpcs_pkg::phase_t               phase_r, phase_nxt;
  logic [lpcs_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [lpcs_pkg::PIX_PTR_W-1:0] pix_r, pix_nxt;
  logic [lpcs_pkg::BIT_PTR_W-1:0] bitp_r, bitp_nxt;
  logic                           cur_r, cur_nxt;

  logic                           busy;
  logic                           do_load;
  logic [lpcs_pkg::TICK_W-1:0]    hi_len;
  logic [lpcs_pkg::TICK_W-1:0]    lo_len;
  logic [lpcs_pkg::CNT_W-1:0]     raw_len;
  logic [lpcs_pkg::CNT_W-1:0]     len;
  logic [lpcs_pkg::CNT_W-1:0]     cnt_inc;

  assign busy    = (phase_r != lpcs_pkg::PH_IDLE);
  assign hi_len  = cur_r ? cfg.one_high_ticks : cfg.zero_high_ticks;
  assign lo_len  = cur_r ? cfg.one_low_ticks : cfg.zero_low_ticks;
  assign cnt_inc = cnt_r + lpcs_pkg::CNT_W'(1);
  assign len     = (raw_len == '0) ? lpcs_pkg::CNT_W'(1) : raw_len;

  always_comb begin
    case (phase_r)
      lpcs_pkg::PH_HIGH: raw_len = lpcs_pkg::CNT_W'(hi_len);
      lpcs_pkg::PH_LOW:  raw_len = lpcs_pkg::CNT_W'(lo_len);
      default:           raw_len = lpcs_pkg::CNT_W'(cfg.latch_ticks);
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    pix_nxt        = pix_r;
    bitp_nxt       = bitp_r;
    cur_nxt        = cur_r;
    do_load        = 1'b0;
    res.data_line  = 1'b0;
    res.busy_res   = busy;
    res.frame_done = 1'b0;
    case (item.action)
      lpcs_pkg::ACT_TICK: begin
        if (busy) begin
          res.data_line = (phase_r == lpcs_pkg::PH_HIGH);
          if (cnt_inc >= len) begin
            cnt_nxt = '0;
            case (phase_r)
              lpcs_pkg::PH_HIGH: phase_nxt = lpcs_pkg::PH_LOW;
              lpcs_pkg::PH_LOW: begin
                if (bitp_r != '0) begin
                  bitp_nxt = bitp_r - lpcs_pkg::BIT_PTR_W'(1);
                  do_load  = 1'b1;
                end else if (pix_r != lpcs_pkg::PIX_PTR_W'(lpcs_pkg::PIXEL_COUNT - 1)) begin
                  pix_nxt  = pix_r + lpcs_pkg::PIX_PTR_W'(1);
                  bitp_nxt = lpcs_pkg::BIT_FIRST;
                  do_load  = 1'b1;
                end else begin
                  phase_nxt = lpcs_pkg::PH_LATCH;
                end
              end
              default: begin
                res.frame_done = 1'b1;
                phase_nxt      = lpcs_pkg::PH_IDLE;
                pix_nxt        = '0;
                bitp_nxt       = lpcs_pkg::BIT_FIRST;
              end
            endcase
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      lpcs_pkg::ACT_START: begin
        if (!busy) begin
          pix_nxt      = '0;
          bitp_nxt     = lpcs_pkg::BIT_FIRST;
          do_load      = 1'b1;
          res.busy_res = 1'b1;
        end
      end
      default: ;
    endcase
    if (do_load) begin
      cur_nxt   = store_r[pix_nxt][bitp_nxt];
      phase_nxt = lpcs_pkg::PH_HIGH;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpcs_pkg::PH_IDLE;
      cnt_r   <= '0;
      pix_r   <= '0;
      bitp_r  <= lpcs_pkg::BIT_FIRST;
      cur_r   <= 1'b0;
    end else if (item_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      pix_r   <= pix_nxt;
      bitp_r  <= bitp_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < lpcs_pkg::PIXEL_COUNT; e++) begin
        store_r[e] <= '0;
      end
    end else if (item_en && !busy) begin
      for (int e = 0; e < lpcs_pkg::PIXEL_COUNT; e++) begin
        if ((item.action == lpcs_pkg::ACT_FILL) ||
            ((item.action == lpcs_pkg::ACT_WRITE) && (int'(item.pixel_index) == e))) begin
          store_r[e] <= item.pixel_color;
        end
      end
    end
  end

  a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (item_en && res.frame_done) |-> res.busy_res)
    else $error("frame_done without busy");

  a_idle_pointers: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lpcs_pkg::PH_IDLE) |-> (pix_r == '0 && bitp_r == lpcs_pkg::BIT_FIRST))
    else $error("pointers not rewound while idle");

  a_line_in_high: assert property (@(posedge clk) disable iff (!rst_n)
    res.data_line |-> (phase_r == lpcs_pkg::PH_HIGH))
    else $error("line high outside high phase");

  a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (item_en && res.frame_done) |=> (phase_r == lpcs_pkg::PH_IDLE))
    else $error("frame_done did not return to idle");

endmodule

[rtl/led_pixel_chain_serializer_unit.sv]
// Single-wire RGBW pixel chain driver.
// in_ch carries items: tick, write one pixel, fill all pixels, start frame.
// Every accepted item yields exactly one result item on out_ch with the
// line level, busy flag and frame_done pulse. A tick item is one tick of
// waveform time; commands do not advance time and are dropped while busy.
// cfg_we/cfg_index/cfg_data write the five timing registers, one per cycle,
// and are only to be written while the block is idle.
// The input register holds each accepted item; its result is computed as
// the item moves on and is presented from the result register.
// Throughput is one item per cycle while out_ch does not stall; the state
// update is one pass of logic between the input and result registers.
// Reset (synchronous, rst_n low) clears the pixel store to zero, empties
// both registers, returns the waveform engine to idle and loads the default
// timings. When out_ch stalls, the result register holds and the input
// register fills; in_ch.ready then drops until the result is taken.
module led_pixel_chain_serializer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  lpcs_in_if.sink                          in_ch,
  lpcs_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [lpcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lpcs_pkg::cfg_t  cfg_r;
  lpcs_pkg::item_t item_r;
  lpcs_pkg::res_t  res;
  lpcs_pkg::res_t  res_r;
  logic            s1_valid_r, s1_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            adv;
  logic            in_acc;

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.action      <= in_ch.action;
      item_r.pixel_index <= in_ch.pixel_index;
      item_r.pixel_color <= in_ch.pixel_color;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_high_ticks  <= lpcs_pkg::ONE_HIGH_RST;
      cfg_r.one_low_ticks   <= lpcs_pkg::ONE_LOW_RST;
      cfg_r.zero_high_ticks <= lpcs_pkg::ZERO_HIGH_RST;
      cfg_r.zero_low_ticks  <= lpcs_pkg::ZERO_LOW_RST;
      cfg_r.latch_ticks     <= lpcs_pkg::LATCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lpcs_pkg::CFG_ONE_HIGH:  cfg_r.one_high_ticks  <= cfg_data[lpcs_pkg::TICK_W-1:0];
        lpcs_pkg::CFG_ONE_LOW:   cfg_r.one_low_ticks   <= cfg_data[lpcs_pkg::TICK_W-1:0];
        lpcs_pkg::CFG_ZERO_HIGH: cfg_r.zero_high_ticks <= cfg_data[lpcs_pkg::TICK_W-1:0];
        lpcs_pkg::CFG_ZERO_LOW:  cfg_r.zero_low_ticks  <= cfg_data[lpcs_pkg::TICK_W-1:0];
        lpcs_pkg::CFG_LATCH:     cfg_r.latch_ticks     <= cfg_data[lpcs_pkg::LATCH_W-1:0];
        default: ;
      endcase
    end
  end

  lpcs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (adv),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_line  = res_r.data_line;
  assign out_ch.busy_res   = res_r.busy_res;
  assign out_ch.frame_done = res_r.frame_done;

endmodule
